/* src/mpq_pkg.sv */
// Shared types and constants for the minimum priority queue cell row.
// Holds the depth, derived widths, status codes, states and the cell control struct.
// No dependencies.
package mpq_pkg;

  localparam int DEPTH   = 16;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int DATA_W  = 32;
  localparam int COUNT_W = 5;

  typedef enum logic [1:0] {
    ST_ENQ = 2'd0,
    ST_DEQ = 2'd1,
    ST_OVF = 2'd2,
    ST_UNF = 2'd3
  } mpq_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_COMPACT,
    S_EMIT
  } mpq_state_e;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } mpq_op_e;

  typedef struct packed {
    logic                     rotate;
    logic                     compact;
    logic                     load;
    logic [IDX_W-1:0]         last_idx;
    logic [IDX_W-1:0]         best_idx;
    logic [IDX_W-1:0]         load_idx;
    logic signed [DATA_W-1:0] head;
    logic signed [DATA_W-1:0] wdata;
  } mpq_ctl_t;

endpackage

/* src/min_priority_queue_array.sv */
// Minimum priority queue held in a row of cells in arrival order.
// Enqueue, overflow, underflow: the result passes through the emit state into the output register;
// a new item is taken only in the idle state. Dequeue: the row rotates once past the head comparator,
// one cell a cycle, then the entries after the minimum shift down in the compact state.
// A new item is taken while the previous result waits in the output register.
// Reset clears the fill count and control; cell contents are undefined until written.
module min_priority_queue_array import mpq_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     op_i,
  input  logic signed [DATA_W-1:0] value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [DATA_W-1:0] out_value_o,
  output logic [1:0]               status_o,
  output logic [COUNT_W-1:0]       count_o
);

  mpq_state_e               state_q, state_d;
  logic [CNT_W-1:0]         fill_q, fill_d;
  logic [IDX_W-1:0]         scan_q, scan_d;
  logic [IDX_W-1:0]         bidx_q, bidx_d;
  logic signed [DATA_W-1:0] best_q, best_d;
  logic signed [DATA_W-1:0] res_value_q, res_value_d;
  mpq_status_e              res_status_q, res_status_d;

  logic                     out_valid_q, out_valid_d;
  logic signed [DATA_W-1:0] out_value_q;
  logic [1:0]               out_status_q;
  logic [COUNT_W-1:0]       out_count_q;

  logic                     accept;
  logic                     emit;
  logic [CNT_W-1:0]         fill_m1;
  mpq_ctl_t                 ctl;
  logic signed [DATA_W-1:0] cell_val [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] nxt;
    if (i == DEPTH - 1) begin : g_end
      assign nxt = '0;
    end else begin : g_mid
      assign nxt = cell_val[i+1];
    end
    mpq_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (IDX_W'(i)),
      .ctl_i   (ctl),
      .next_i  (nxt),
      .value_o (cell_val[i])
    );
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign emit       = (state_q == S_EMIT) && (!out_valid_q || out_ready_i);
  assign fill_m1    = fill_q - CNT_W'(1);

  always_comb begin
    state_d      = state_q;
    fill_d       = fill_q;
    scan_d       = scan_q;
    bidx_d       = bidx_q;
    best_d       = best_q;
    res_value_d  = res_value_q;
    res_status_d = res_status_q;
    ctl          = '0;
    ctl.last_idx = fill_m1[IDX_W-1:0];
    ctl.best_idx = bidx_q;
    ctl.load_idx = fill_q[IDX_W-1:0];
    ctl.head     = cell_val[0];
    ctl.wdata    = value_i;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_value_d = '0;
          state_d     = S_EMIT;
          if (op_i == OP_ENQ) begin
            if (fill_q == CNT_W'(DEPTH)) begin
              res_status_d = ST_OVF;
            end else begin
              ctl.load     = 1'b1;
              fill_d       = fill_q + CNT_W'(1);
              res_status_d = ST_ENQ;
            end
          end else if (fill_q == '0) begin
            res_status_d = ST_UNF;
          end else begin
            scan_d  = '0;
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        ctl.rotate = 1'b1;
        if ((scan_q == '0) || (cell_val[0] < best_q)) begin
          best_d = cell_val[0];
          bidx_d = scan_q;
        end
        if (scan_q == fill_m1[IDX_W-1:0]) begin
          state_d = S_COMPACT;
        end else begin
          scan_d = scan_q + IDX_W'(1);
        end
      end
      S_COMPACT: begin
        ctl.compact  = 1'b1;
        fill_d       = fill_m1;
        res_value_d  = best_q;
        res_status_d = ST_DEQ;
        state_d      = S_EMIT;
      end
      S_EMIT: begin
        if (emit) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      fill_q  <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q       <= scan_d;
    bidx_q       <= bidx_d;
    best_q       <= best_d;
    res_value_q  <= res_value_d;
    res_status_q <= res_status_d;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_value_q  <= res_value_q;
      out_status_q <= res_status_q;
      out_count_q  <= COUNT_W'(fill_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign status_o    = out_status_q;
  assign count_o     = out_count_q;

  a_fill_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(DEPTH))
    else $error("fill count above depth");

  a_scan_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> ((fill_q != '0) && (CNT_W'(scan_q) < fill_q)))
    else $error("scan step outside stored entries");

  a_compact_drop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COMPACT) |=> (fill_q == $past(fill_m1)))
    else $error("compaction did not drop one entry");

  a_zero_value : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q != ST_DEQ)) |-> (out_value_q == '0))
    else $error("nonzero value on a result that is not a dequeue");

endmodule

/* src/mpq_cell.sv */
// One storage cell of the queue row.
// Takes its right neighbor, the row head or the write data under the shared control.
// Depends on mpq_pkg.
module mpq_cell import mpq_pkg::*; (
  input  logic                     clk_i,
  input  logic [IDX_W-1:0]         idx_i,
  input  mpq_ctl_t                 ctl_i,
  input  logic signed [DATA_W-1:0] next_i,
  output logic signed [DATA_W-1:0] value_o
);

  logic signed [DATA_W-1:0] value_q, value_d;

  always_comb begin
    value_d = value_q;
    if (ctl_i.rotate) begin
      if (idx_i < ctl_i.last_idx) begin
        value_d = next_i;
      end else if (idx_i == ctl_i.last_idx) begin
        value_d = ctl_i.head;
      end
    end
    if (ctl_i.compact && (idx_i >= ctl_i.best_idx) && (idx_i < ctl_i.last_idx)) begin
      value_d = next_i;
    end
    if (ctl_i.load && (idx_i == ctl_i.load_idx)) begin
      value_d = ctl_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule
